@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spline evaluator checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CHSE_ASSERT(label, clk_s, rst_s, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// Expression must never be true at a clock edge out of reset.
`define CHSE_ASSERT_NEVER(label, clk_s, rst_s, expr, msg) \
    `CHSE_ASSERT(label, clk_s, rst_s, !(expr), msg)

`endif

@@ hdl/chse_pkg.sv @@
// ----------------------------------------------------------------------------
// chse_pkg
// Types, register indexes and arithmetic helpers for the cubic Hermite
// spline evaluator.
// ----------------------------------------------------------------------------
package chse_pkg;

    localparam int W    = 40;          // internal accumulator width
    localparam int TW   = 17;          // parameter width, Q1.16
    localparam int PW   = W + TW + 1;  // product width
    localparam int DW   = 32;          // register and output width
    localparam int NREG = 8;
    localparam int IW   = 3;
    localparam int NAX  = 2;

    localparam logic [TW-1:0] ONE = 17'h10000;

    localparam logic [IW-1:0] REG_START_X     = 3'd0;
    localparam logic [IW-1:0] REG_START_Y     = 3'd1;
    localparam logic [IW-1:0] REG_END_X       = 3'd2;
    localparam logic [IW-1:0] REG_END_Y       = 3'd3;
    localparam logic [IW-1:0] REG_START_TAN_X = 3'd4;
    localparam logic [IW-1:0] REG_START_TAN_Y = 3'd5;
    localparam logic [IW-1:0] REG_END_TAN_X   = 3'd6;
    localparam logic [IW-1:0] REG_END_TAN_Y   = 3'd7;

    typedef logic signed [W-1:0]  acc_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [DW-1:0] word_t;
    typedef logic [TW-1:0]        t_t;

    typedef struct packed {
        acc_t c3;
        acc_t k3;   // 3*c3
        acc_t k6;   // 6*c3
        acc_t c2;
        acc_t k2;   // 2*c2
    } coef_t;

    localparam acc_t MAXV = acc_t'(32'sh7FFF_FFFF);
    localparam acc_t MINV = ~MAXV;

    function automatic coef_t make_coef(word_t p0, word_t p1, word_t v0, word_t v1);
        coef_t c;
        acc_t  ep0;
        acc_t  ep1;
        acc_t  ev0;
        acc_t  ev1;
        ep0  = acc_t'(p0);
        ep1  = acc_t'(p1);
        ev0  = acc_t'(v0);
        ev1  = acc_t'(v1);
        c.c3 = (ep0 <<< 1) - (ep1 <<< 1) + ev0 + ev1;
        c.k3 = (c.c3 <<< 1) + c.c3;
        c.k6 = c.k3 <<< 1;
        c.c2 = (ep1 <<< 1) + ep1 - (ep0 <<< 1) - ep0 - (ev0 <<< 1) - ev1;
        c.k2 = c.c2 <<< 1;
        return c;
    endfunction

    function automatic prod_t mul(acc_t a, t_t t);
        prod_t pa;
        prod_t pt;
        pa = prod_t'(a);
        pt = prod_t'({1'b0, t});
        return pa * pt;
    endfunction

    // Q.32 back to Q16.16, round half away from zero.
    function automatic acc_t rnd(prod_t x);
        prod_t s;
        s = x + prod_t'(32768) - prod_t'(x[PW-1]);
        return s[W+15:16];
    endfunction

    function automatic word_t sat(acc_t v);
        word_t r;
        if (v > MAXV)
        begin
            r = MAXV[DW-1:0];
        end
        else if (v < MINV)
        begin
            r = MINV[DW-1:0];
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/cubic_hermite_spline_eval_core.sv @@
// ----------------------------------------------------------------------------
// cubic_hermite_spline_eval_core
// Pipelined 2-D cubic Hermite spline evaluator: position, first and second
// derivative for x and y at a Q1.16 parameter, Q16.16 saturated results.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  input     start / busy       param
//  result    done (strobe)      pos_x pos_y deriv_x deriv_y second_x second_y
//  config    cfg_wr_en          cfg_index cfg_data
//
//  One param per cycle; each result appears together with its done strobe.
//  Latency is set by the three-step Horner chain for position: each multiply
//  and its round/add take a stage of their own.
//  Reset clears the spline registers to zero and empties the pipeline.
//  busy stays low; done is a one-cycle strobe per beat, no stalls.
// ----------------------------------------------------------------------------
module cubic_hermite_spline_eval_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  chse_pkg::t_t         param,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 done,
    output chse_pkg::word_t      pos_x,
    output chse_pkg::word_t      pos_y,
    output chse_pkg::word_t      deriv_x,
    output chse_pkg::word_t      deriv_y,
    output chse_pkg::word_t      second_x,
    output chse_pkg::word_t      second_y
);

    chse_pkg::word_t cfg_reg  [chse_pkg::NREG];
    chse_pkg::word_t cfg_next [chse_pkg::NREG];
    chse_pkg::coef_t coef_reg  [chse_pkg::NAX];
    chse_pkg::coef_t coef_next [chse_pkg::NAX];

    logic [6:0]   v_reg;
    logic         done_reg;
    chse_pkg::t_t t_reg [5];

    chse_pkg::prod_t pa_reg  [chse_pkg::NAX];
    chse_pkg::prod_t pb_reg  [chse_pkg::NAX];
    chse_pkg::prod_t pc_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  h1_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  d1_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  s3_reg  [chse_pkg::NAX];
    chse_pkg::prod_t ph4_reg [chse_pkg::NAX];
    chse_pkg::prod_t pd4_reg [chse_pkg::NAX];
    chse_pkg::acc_t  s4_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  h2_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  d2_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  s5_reg  [chse_pkg::NAX];
    chse_pkg::prod_t ph6_reg [chse_pkg::NAX];
    chse_pkg::acc_t  d6_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  s6_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  h3_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  d7_reg  [chse_pkg::NAX];
    chse_pkg::acc_t  s7_reg  [chse_pkg::NAX];
    chse_pkg::word_t pos_reg [chse_pkg::NAX];
    chse_pkg::word_t der_reg [chse_pkg::NAX];
    chse_pkg::word_t sec_reg [chse_pkg::NAX];

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        for (int i = 0; i < chse_pkg::NREG; i++)
        begin
            if (cfg_wr_en && (cfg_index == chse_pkg::IW'(i)))
            begin
                cfg_next[i] = cfg_data;
            end
            else
            begin
                cfg_next[i] = cfg_reg[i];
            end
        end
        for (int a = 0; a < chse_pkg::NAX; a++)
        begin
            coef_next[a] = chse_pkg::make_coef(
                cfg_next[chse_pkg::IW'(chse_pkg::REG_START_X + a)],
                cfg_next[chse_pkg::IW'(chse_pkg::REG_END_X + a)],
                cfg_next[chse_pkg::IW'(chse_pkg::REG_START_TAN_X + a)],
                cfg_next[chse_pkg::IW'(chse_pkg::REG_END_TAN_X + a)]);
        end
    end

    // control and spline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chse_pkg::NREG; i++)
            begin
                cfg_reg[i] <= '0;
            end
            for (int a = 0; a < chse_pkg::NAX; a++)
            begin
                coef_reg[a] <= '0;
            end
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < chse_pkg::NREG; i++)
            begin
                cfg_reg[i] <= cfg_next[i];
            end
            for (int a = 0; a < chse_pkg::NAX; a++)
            begin
                coef_reg[a] <= coef_next[a];
            end
            v_reg    <= {v_reg[5:0], accept};
            done_reg <= v_reg[6];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        t_reg[0] <= (param > chse_pkg::ONE) ? chse_pkg::ONE : param;
        for (int k = 1; k < 5; k++)
        begin
            t_reg[k] <= t_reg[k-1];
        end
        for (int a = 0; a < chse_pkg::NAX; a++)
        begin
            pa_reg[a]  <= chse_pkg::mul(coef_reg[a].c3, t_reg[0]);
            pb_reg[a]  <= chse_pkg::mul(coef_reg[a].k3, t_reg[0]);
            pc_reg[a]  <= chse_pkg::mul(coef_reg[a].k6, t_reg[0]);

            h1_reg[a]  <= chse_pkg::rnd(pa_reg[a]) + coef_reg[a].c2;
            d1_reg[a]  <= chse_pkg::rnd(pb_reg[a]) + coef_reg[a].k2;
            s3_reg[a]  <= chse_pkg::rnd(pc_reg[a]) + coef_reg[a].k2;

            ph4_reg[a] <= chse_pkg::mul(h1_reg[a], t_reg[2]);
            pd4_reg[a] <= chse_pkg::mul(d1_reg[a], t_reg[2]);
            s4_reg[a]  <= s3_reg[a];

            h2_reg[a]  <= chse_pkg::rnd(ph4_reg[a]) + chse_pkg::acc_t'(
                              cfg_reg[chse_pkg::IW'(chse_pkg::REG_START_TAN_X + a)]);
            d2_reg[a]  <= chse_pkg::rnd(pd4_reg[a]) + chse_pkg::acc_t'(
                              cfg_reg[chse_pkg::IW'(chse_pkg::REG_START_TAN_X + a)]);
            s5_reg[a]  <= s4_reg[a];

            ph6_reg[a] <= chse_pkg::mul(h2_reg[a], t_reg[4]);
            d6_reg[a]  <= d2_reg[a];
            s6_reg[a]  <= s5_reg[a];

            h3_reg[a]  <= chse_pkg::rnd(ph6_reg[a]) + chse_pkg::acc_t'(
                              cfg_reg[chse_pkg::IW'(chse_pkg::REG_START_X + a)]);
            d7_reg[a]  <= d6_reg[a];
            s7_reg[a]  <= s6_reg[a];

            pos_reg[a] <= chse_pkg::sat(h3_reg[a]);
            der_reg[a] <= chse_pkg::sat(d7_reg[a]);
            sec_reg[a] <= chse_pkg::sat(s7_reg[a]);
        end
    end

    assign done     = done_reg;
    assign pos_x    = pos_reg[0];
    assign pos_y    = pos_reg[1];
    assign deriv_x  = der_reg[0];
    assign deriv_y  = der_reg[1];
    assign second_x = sec_reg[0];
    assign second_y = sec_reg[1];

endmodule

@@ hdl/chse_checker.sv @@
// ----------------------------------------------------------------------------
// chse_checker
// Port-level checks on the spline evaluator: fixed latency, no stray
// results, repeatable results for a repeated parameter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chse_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [16:0] param,
    input logic        cfg_wr_en,
    input logic        done,
    input logic [31:0] pos_x,
    input logic [31:0] pos_y,
    input logic [31:0] deriv_x,
    input logic [31:0] deriv_y,
    input logic [31:0] second_x,
    input logic [31:0] second_y
);

    logic       accept;
    logic [3:0] quiet_reg;
    logic [3:0] quiet_next;

    assign accept = start && !busy;

    // edges since the last register write, saturating
    always_comb
    begin
        if (cfg_wr_en)
        begin
            quiet_next = '0;
        end
        else if (quiet_reg == 4'hF)
        begin
            quiet_next = quiet_reg;
        end
        else
        begin
            quiet_next = quiet_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_reg <= '0;
        end
        else
        begin
            quiet_reg <= quiet_next;
        end
    end

    `CHSE_ASSERT(a_latency, clk, rst_n, accept |-> ##8 done, "accepted beat gave no result")

    `CHSE_ASSERT_NEVER(a_no_stray, clk, rst_n, done && !$past(accept, 8), "result with no beat")

    `CHSE_ASSERT(a_repeat, clk, rst_n,
        (done && $past(done) && ($past(param, 8) == $past(param, 9)) && (quiet_reg >= 4'd9))
        |-> ($stable(pos_x) && $stable(pos_y) && $stable(deriv_x) && $stable(deriv_y)
             && $stable(second_x) && $stable(second_y)),
        "same param gave different result")

endmodule

bind cubic_hermite_spline_eval_core chse_checker u_chse_checker (.*);
